### hdl/msra_pkg.sv
// Package with the item types, opcodes and status codes of the register ALU.
package msra_pkg;

  localparam int unsigned RegCount = 32;
  localparam logic [4:0] LoReg = 5'd30;
  localparam logic [4:0] HiReg = 5'd31;

  typedef enum logic [5:0] {
    OP_ADD = 6'd0, OP_ADDU = 6'd1, OP_ADDI = 6'd2, OP_ADDIU = 6'd3,
    OP_SUB = 6'd4, OP_SUBU = 6'd5, OP_MULT = 6'd6, OP_MULTU = 6'd7,
    OP_MFHI = 6'd8, OP_MFLO = 6'd9, OP_AND = 6'd10, OP_ANDI = 6'd11,
    OP_OR = 6'd12, OP_ORI = 6'd13, OP_XOR = 6'd14, OP_XORI = 6'd15,
    OP_NOR = 6'd16, OP_SLT = 6'd17, OP_SLTU = 6'd18, OP_SLTI = 6'd19,
    OP_SLL = 6'd20, OP_SRL = 6'd21, OP_SRA = 6'd22, OP_SLLV = 6'd23,
    OP_SRLV = 6'd24, OP_SRAV = 6'd25, OP_MOVE = 6'd26, OP_CLEAR = 6'd27,
    OP_NOT = 6'd28, OP_LI = 6'd29, OP_PRINTU = 6'd30, OP_PRINTS = 6'd31
  } opcode_t;

  typedef enum logic [1:0] {
    ST_SILENT = 2'd0,
    ST_PRINT = 2'd1,
    ST_UNKNOWN = 2'd2
  } status_t;

  typedef struct packed {
    logic [5:0] mode;
    logic [4:0] reg_first;
    logic [4:0] reg_second;
    logic [4:0] reg_third;
    logic [31:0] immediate;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [31:0] print_value;
    logic print_signed;
  } out_item_t;

  // Classified instruction passed from the front to the back.
  typedef struct packed {
    logic known;
    opcode_t op;
    logic [4:0] reg_first;
    logic [4:0] reg_second;
    logic [4:0] reg_third;
    logic [31:0] immediate;
  } cmd_t;

endpackage

### hdl/msra_front.sv
// Front part: accepts items, classifies the opcode and holds a two-entry command queue.
module msra_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  msra_pkg::in_item_t in_item,
  output logic              cmd_valid,
  input  logic              cmd_take,
  output msra_pkg::cmd_t    cmd
);
  import msra_pkg::*;

  cmd_t q [2];
  logic [1:0] count;
  logic rd_ptr;
  logic wr_ptr;
  logic do_push;
  logic do_pop;
  cmd_t incoming;

  assign full = count[1];
  assign cmd_valid = count != 2'd0;
  assign cmd = q[rd_ptr];
  assign do_push = push && !full;
  assign do_pop = cmd_take && cmd_valid;

  always_comb begin
    incoming.known = !in_item.mode[5];
    incoming.op = opcode_t'(in_item.mode);
    incoming.reg_first = in_item.reg_first;
    incoming.reg_second = in_item.reg_second;
    incoming.reg_third = in_item.reg_third;
    incoming.immediate = in_item.immediate;
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= incoming;
    end
    if (rst) begin
      count <= 2'd0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

### hdl/msra_back.sv
// Back part: register file, ALU, multiplier write-back and the result register.
module msra_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_take,
  input  msra_pkg::cmd_t     cmd,
  output logic               empty,
  input  logic               pop,
  output msra_pkg::out_item_t out_item
);
  import msra_pkg::*;

  logic [31:0] regs [RegCount];
  logic [RegCount-1:0] written;
  logic [31:0] a;
  logic [31:0] b;
  logic [31:0] d;
  logic [31:0] hi;
  logic [31:0] lo;
  logic [31:0] wval;
  logic wen;
  logic is_mul;
  logic [63:0] prod;
  logic [4:0] amt;
  logic out_valid;
  out_item_t res;

  function automatic logic [31:0] rd(input logic [4:0] idx, input logic [RegCount-1:0] w,
                                     input logic [31:0] v);
    logic [31:0] r;
    r = (idx == 5'd0 || !w[idx]) ? 32'd0 : v;
    return r;
  endfunction

  assign a = rd(cmd.reg_second, written, regs[cmd.reg_second]);
  assign b = rd(cmd.reg_third, written, regs[cmd.reg_third]);
  assign d = rd(cmd.reg_first, written, regs[cmd.reg_first]);
  assign hi = rd(HiReg, written, regs[HiReg]);
  assign lo = rd(LoReg, written, regs[LoReg]);
  assign prod = {32'd0, d} * {32'd0, a};
  assign empty = !out_valid;
  assign cmd_take = cmd_valid && (!out_valid || pop);

  always_comb begin
    wen = cmd.known;
    is_mul = 1'b0;
    wval = 32'd0;
    amt = cmd.immediate[4:0];
    res.status = ST_SILENT;
    res.print_value = 32'd0;
    res.print_signed = 1'b0;
    if (!cmd.known) begin
      res.status = ST_UNKNOWN;
    end else begin
      case (cmd.op)
        OP_ADD, OP_ADDU: wval = a + b;
        OP_ADDI, OP_ADDIU: wval = a + cmd.immediate;
        OP_SUB, OP_SUBU: wval = a - b;
        OP_MULT, OP_MULTU: begin
          wen = 1'b0;
          is_mul = 1'b1;
        end
        OP_MFHI: wval = hi;
        OP_MFLO: wval = lo;
        OP_AND: wval = a & b;
        OP_ANDI: wval = a & cmd.immediate;
        OP_OR: wval = a | b;
        OP_ORI: wval = a | cmd.immediate;
        OP_XOR: wval = a ^ b;
        OP_XORI: wval = a ^ cmd.immediate;
        OP_NOR: wval = ~(a | b);
        OP_SLT: wval = {31'd0, $signed(a) < $signed(b)};
        OP_SLTU: wval = {31'd0, a < b};
        OP_SLTI: wval = {31'd0, $signed(a) < $signed(cmd.immediate)};
        OP_SLL: wval = a << amt;
        OP_SRL: wval = a >> amt;
        OP_SRA: wval = 32'($signed(a) >>> amt);
        OP_SLLV: wval = a << b[4:0];
        OP_SRLV: wval = a >> b[4:0];
        OP_SRAV: wval = 32'($signed(a) >>> b[4:0]);
        OP_MOVE: wval = a;
        OP_CLEAR: wval = 32'd0;
        OP_NOT: wval = ~a;
        OP_LI: wval = cmd.immediate;
        OP_PRINTU, OP_PRINTS: begin
          wen = 1'b0;
          res.status = ST_PRINT;
          res.print_value = d;
          res.print_signed = cmd.op == OP_PRINTS;
        end
        default: wen = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      out_item <= res;
      if (wen) regs[cmd.reg_first] <= wval;
      if (is_mul) begin
        regs[LoReg] <= prod[31:0];
        regs[HiReg] <= prod[63:32];
      end
    end
    if (rst) begin
      out_valid <= 1'b0;
      written <= '0;
    end else begin
      if (cmd_take) begin
        out_valid <= 1'b1;
        if (wen) written[cmd.reg_first] <= 1'b1;
        if (is_mul) begin
          written[LoReg] <= 1'b1;
          written[HiReg] <= 1'b1;
        end
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### hdl/mips_subset_register_alu.sv
// Top level of the register ALU: front queue and back execution unit.
//
// Channel   Direction  Handshake       Payload
// input     in         push / full     in_item  (mode, reg_first, reg_second, reg_third, immediate)
// result    out        empty / pop     out_item (status, print_value, print_signed)
//
// One item per cycle is sustained while results are popped without stall. An accepted item
// waits in the queue, then the back part registers its result. The register file is read and
// written in the same cycle as the ALU, so items follow back to back. Reset clears the
// queue, the result valid flag and the register valid bits, so all registers read zero.
// A stalled result holds the back part; the two-entry queue keeps accepting until it fills.
module mips_subset_register_alu (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  msra_pkg::in_item_t  in_item,
  output logic                empty,
  input  logic                pop,
  output msra_pkg::out_item_t out_item
);
  import msra_pkg::*;

  logic cmd_valid;
  logic cmd_take;
  cmd_t cmd;

  msra_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd)
  );

  msra_back u_back (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd),
    .empty(empty), .pop(pop), .out_item(out_item)
  );

endmodule

### tb/msra_checker.sv
// Checker that predicts register ALU results and compares them with the result channel.
`timescale 1ns / 100ps
module msra_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic                full,
  input  msra_pkg::in_item_t  in_item,
  input  logic                empty,
  input  logic                pop,
  input  msra_pkg::out_item_t out_item,
  output int                  fail_count,
  output int                  pending_count
);
  import msra_pkg::*;

  logic [31:0] shadow_regs [RegCount];
  out_item_t expected_results[$];

  function automatic logic [31:0] read_shadow(logic [4:0] idx);
    return (idx == 5'd0) ? 32'd0 : shadow_regs[idx];
  endfunction

  function automatic logic signed_less(logic [31:0] a, logic [31:0] b);
    return $signed(a) < $signed(b);
  endfunction

  task automatic execute_instruction(in_item_t it);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] res;
    logic [63:0] prod;
    logic write_en;
    out_item_t o;
    a = read_shadow(it.reg_second);
    b = read_shadow(it.reg_third);
    res = '0;
    write_en = 1'b1;
    o = '0;
    o.status = ST_SILENT;
    if (it.mode > 6'd31) begin
      write_en = 1'b0;
      o.status = ST_UNKNOWN;
    end else begin
      case (opcode_t'(it.mode))
        OP_ADD, OP_ADDU: res = a + b;
        OP_ADDI, OP_ADDIU: res = a + it.immediate;
        OP_SUB, OP_SUBU: res = a - b;
        OP_MULT, OP_MULTU: begin
          prod = {32'd0, read_shadow(it.reg_first)} * {32'd0, a};
          shadow_regs[LoReg] = prod[31:0];
          shadow_regs[HiReg] = prod[63:32];
          write_en = 1'b0;
        end
        OP_MFHI: res = read_shadow(HiReg);
        OP_MFLO: res = read_shadow(LoReg);
        OP_AND: res = a & b;
        OP_ANDI: res = a & it.immediate;
        OP_OR: res = a | b;
        OP_ORI: res = a | it.immediate;
        OP_XOR: res = a ^ b;
        OP_XORI: res = a ^ it.immediate;
        OP_NOR: res = ~(a | b);
        OP_SLT: res = {31'd0, signed_less(a, b)};
        OP_SLTU: res = {31'd0, a < b};
        OP_SLTI: res = {31'd0, signed_less(a, it.immediate)};
        OP_SLL: res = a << it.immediate[4:0];
        OP_SRL: res = a >> it.immediate[4:0];
        OP_SRA: res = $signed(a) >>> it.immediate[4:0];
        OP_SLLV: res = a << b[4:0];
        OP_SRLV: res = a >> b[4:0];
        OP_SRAV: res = $signed(a) >>> b[4:0];
        OP_MOVE: res = a;
        OP_CLEAR: res = 32'd0;
        OP_NOT: res = ~a;
        OP_LI: res = it.immediate;
        OP_PRINTU, OP_PRINTS: begin
          write_en = 1'b0;
          o.status = ST_PRINT;
          o.print_value = read_shadow(it.reg_first);
          o.print_signed = (it.mode == OP_PRINTS);
        end
        default: write_en = 1'b0;
      endcase
    end
    if (write_en && it.reg_first != 5'd0) shadow_regs[it.reg_first] = res;
    expected_results.insert(expected_results.size(), o);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      for (int i = 0; i < RegCount; i++) shadow_regs[i] = '0;
      expected_results.delete();
      fail_count <= 0;
    end else begin
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected item: actual %h", $time, out_item);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (want.status != out_item.status || want.print_value != out_item.print_value ||
              want.print_signed != out_item.print_signed) begin
            $display("%0t: mismatch: expected %h actual %h", $time, want, out_item);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (push && !full) execute_instruction(in_item);
    end
    pending_count = expected_results.size();
  end
endmodule

### tb/tb_mips_subset_register_alu.sv
// Testbench top for the register ALU: stimulus, clock, reset and verdict.
`timescale 1ns / 100ps
module tb_mips_subset_register_alu;
  import msra_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full;
  logic empty;
  in_item_t in_item = '0;
  out_item_t out_item;
  int fail_count;
  int pending_count;
  int idle_cycles = 0;

  always #6 clk = ~clk;

  mips_subset_register_alu u_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item)
  );

  msra_checker u_checker (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] random_word();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return 32'($urandom_range(0, 40));
      default: return $urandom;
    endcase
  endfunction

  task automatic send_instruction(logic [5:0] mode, logic [4:0] rf, logic [4:0] rs,
                                  logic [4:0] rt, logic [31:0] imm);
    push <= 1'b1;
    in_item <= '{mode: mode, reg_first: rf, reg_second: rs, reg_third: rt, immediate: imm};
    do @(posedge clk); while (full);
  endtask

  task automatic send_random();
    int r;
    int gap;
    logic [5:0] mode;
    r = $urandom_range(0, 99);
    if (r < 20) mode = OP_LI;
    else if (r < 28) mode = 6'($urandom_range(32, 63));
    else if (r < 38) mode = 6'($urandom_range(OP_PRINTU, OP_PRINTS));
    else mode = 6'($urandom_range(0, 31));
    send_instruction(mode, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                     5'($urandom_range(0, 31)), random_word());
    gap = gap_length();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  always begin
    @(posedge clk);
    if (!rst && gap_length() == 0) begin
      pop <= 1'b1;
    end else if (!rst) begin
      pop <= ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 2000) begin
        $display("tb_mips_subset_register_alu NOT OK");
        $finish;
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_instruction(OP_LI, 5'd1, 5'd0, 5'd0, 32'hFFFF_FFFF);
    send_instruction(OP_LI, 5'd2, 5'd0, 5'd0, 32'h8000_0000);
    send_instruction(OP_LI, 5'd0, 5'd0, 5'd0, 32'h1234_5678);
    send_instruction(OP_PRINTU, 5'd0, 5'd0, 5'd0, 32'd0);
    send_instruction(OP_MULTU, 5'd1, 5'd1, 5'd0, 32'd0);
    send_instruction(OP_MFHI, 5'd3, 5'd0, 5'd0, 32'd0);
    send_instruction(OP_MFLO, 5'd4, 5'd0, 5'd0, 32'd0);
    send_instruction(OP_SRA, 5'd5, 5'd2, 5'd0, 32'hFFFF_FFFF);
    send_instruction(OP_SRAV, 5'd6, 5'd2, 5'd1, 32'd0);
    send_instruction(OP_SLT, 5'd7, 5'd2, 5'd1, 32'd0);
    send_instruction(OP_SLTU, 5'd8, 5'd2, 5'd1, 32'd0);
    send_instruction(OP_SLTI, 5'd9, 5'd1, 5'd0, 32'h8000_0000);
    send_instruction(OP_ADD, 5'd10, 5'd1, 5'd2, 32'd0);
    send_instruction(OP_SUB, 5'd11, 5'd0, 5'd1, 32'd0);
    send_instruction(OP_SLL, 5'd12, 5'd1, 5'd0, 32'd33);
    send_instruction(6'd63, 5'd31, 5'd31, 5'd31, 32'hFFFF_FFFF);
    for (int m = 0; m < 32; m += 4) begin
      send_instruction(m[5:0], 5'd13, 5'd1, 5'd2, 32'h5A5A_A5A5);
    end
    for (int r = 1; r < 32; r += 6) begin
      send_instruction(OP_PRINTS, r[4:0], 5'd0, 5'd0, 32'd0);
    end
    for (int n = 0; n < 850; n++) begin
      if (n == 400) begin
        push <= 1'b0;
        wait (pending_count == 0);
        @(posedge clk);
      end
      send_random();
    end
    push <= 1'b0;
    wait (pending_count == 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_mips_subset_register_alu OK");
    end else begin
      $display("tb_mips_subset_register_alu NOT OK");
    end
    $finish;
  end
endmodule

### sim.f
hdl/msra_pkg.sv
hdl/msra_front.sv
hdl/msra_back.sv
hdl/mips_subset_register_alu.sv
tb/msra_checker.sv
tb/tb_mips_subset_register_alu.sv
